FILE: rtl/eppc_pkg.sv
// Package for the edge projector: widths, register indexes, lane codes,
// shared structs and the axis dot product. No dependencies.
`default_nettype none
package eppc_pkg;

  localparam int COORD_W    = 24;
  localparam int AXIS_W     = 16;
  localparam int DIFF_W     = COORD_W + 1;
  localparam int DOT_W      = 43;
  localparam int DIST_W     = 16;
  localparam int HALF_W     = 15;
  localparam int PIX_W      = 16;
  localparam int REG_W      = 64;
  localparam int ADDR_W     = 6;
  localparam int IDX_W      = 3;
  localparam int COORD_FRAC = 8;
  localparam int AXIS_FRAC  = 14;

  // Split point of the wide clip products.
  localparam int SPLIT  = 22;
  localparam int NN_W   = 45;
  localparam int PNUM_W = DOT_W + DIST_W + 1;
  localparam int NUM_W  = 90;
  localparam int DEN_W  = 66;

  // Pixel lane arithmetic.
  localparam int MAG_W   = NUM_W - 1;
  localparam int MSPLIT  = 45;
  localparam int HM_W    = MAG_W + HALF_W;
  localparam int N_W     = HM_W + 2;
  localparam int QUO_W   = 16;
  localparam int DVS_W   = DEN_W + 1;
  localparam int REM_W   = DVS_W + QUO_W;
  localparam int OFF_W   = QUO_W + 1;
  localparam int VAL_W   = 18;
  localparam int LANE_LAT  = QUO_W + 5;
  localparam int FRONT_LAT = 5;
  localparam int TOTAL_LAT = FRONT_LAT + LANE_LAT;
  localparam int NUM_LANES = 6;

  localparam logic [OFF_W-1:0] OFF_CAP = OFF_W'(65536);
  localparam logic signed [VAL_W-1:0] PIX_MAX = VAL_W'(32767);
  localparam logic signed [VAL_W-1:0] PIX_MIN = -VAL_W'(32768);

  // Register indexes.
  localparam logic [IDX_W-1:0] REG_CAM_X = 3'd0;
  localparam logic [IDX_W-1:0] REG_CAM_Y = 3'd1;
  localparam logic [IDX_W-1:0] REG_CAM_Z = 3'd2;
  localparam logic [IDX_W-1:0] REG_RIGHT = 3'd3;
  localparam logic [IDX_W-1:0] REG_UP    = 3'd4;
  localparam logic [IDX_W-1:0] REG_FWD   = 3'd5;
  localparam logic [IDX_W-1:0] REG_DIST  = 3'd6;
  localparam logic [IDX_W-1:0] REG_HALF  = 3'd7;

  // Lane override codes.
  typedef logic [1:0] spec_t;
  localparam spec_t SPEC_NONE = 2'd0;
  localparam spec_t SPEC_POS  = 2'd1;
  localparam spec_t SPEC_NEG  = 2'd2;
  localparam spec_t SPEC_CTR  = 2'd3;

  typedef struct packed {
    logic signed [COORD_W-1:0] cam_x;
    logic signed [COORD_W-1:0] cam_y;
    logic signed [COORD_W-1:0] cam_z;
    logic [3*AXIS_W-1:0]       right;
    logic [3*AXIS_W-1:0]       up;
    logic [3*AXIS_W-1:0]       fwd;
    logic [DIST_W-1:0]         scr_dist;
    logic [HALF_W-1:0]         half;
  } cfg_t;

  typedef struct packed {
    logic signed [NUM_W-1:0] num;
    logic                    flip;
    logic [DEN_W-1:0]        den;
    spec_t                   spec;
  } lane_in_t;

  typedef struct packed {
    logic vld;
    logic fa;
    logic fb;
    logic par;
  } flag_t;

  // Dot product of an offset with a packed axis register.
  function automatic logic signed [DOT_W-1:0] dot3(
    input logic signed [DIFF_W-1:0] dx,
    input logic signed [DIFF_W-1:0] dy,
    input logic signed [DIFF_W-1:0] dz,
    input logic [3*AXIS_W-1:0]      ax
  );
    logic signed [DOT_W-1:0] px;
    logic signed [DOT_W-1:0] py;
    logic signed [DOT_W-1:0] pz;
    px = DOT_W'(dx) * DOT_W'($signed(ax[AXIS_W-1:0]));
    py = DOT_W'(dy) * DOT_W'($signed(ax[2*AXIS_W-1:AXIS_W]));
    pz = DOT_W'(dz) * DOT_W'($signed(ax[3*AXIS_W-1:2*AXIS_W]));
    return px + py + pz;
  endfunction

endpackage
`default_nettype wire

FILE: rtl/edge_perspective_project_clip.sv
// Top level of the edge projector: config registers, front end, six pixel
// lanes and the merge stage. Depends on eppc_pkg, eppc_cfg, eppc_front, eppc_lane.
//
//  channel   handshake          payload
//  input     start / busy       in_end_a_x .. in_end_b_z
//  result    out_valid (strobe) out_pix_a_x .. out_clip_parallel
//  config    psel/penable/...   paddr, pwdata, prdata
//
// An item is taken every cycle; busy stays low. Each result passes through 27
// register stages, 5 in the front end, 21 in the lanes (a 16-stage restoring
// divider) and the output register, the first of them loaded at the accepting
// edge. Four lanes project the endpoints, two compute the plane crossing; the
// merge picks per end. Reset is synchronous and clears the valid pipeline
// and the config registers. Results cannot be stalled; out_valid is high for
// exactly one cycle.
`default_nettype none
module edge_perspective_project_clip
  import eppc_pkg::*;
(
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      start,
  output logic                           busy,
  input  wire logic signed [COORD_W-1:0] in_end_a_x,
  input  wire logic signed [COORD_W-1:0] in_end_a_y,
  input  wire logic signed [COORD_W-1:0] in_end_a_z,
  input  wire logic signed [COORD_W-1:0] in_end_b_x,
  input  wire logic signed [COORD_W-1:0] in_end_b_y,
  input  wire logic signed [COORD_W-1:0] in_end_b_z,
  output logic                           out_valid,
  output logic signed [PIX_W-1:0]        out_pix_a_x,
  output logic signed [PIX_W-1:0]        out_pix_a_y,
  output logic signed [PIX_W-1:0]        out_pix_b_x,
  output logic signed [PIX_W-1:0]        out_pix_b_y,
  output logic                           out_a_in_front,
  output logic                           out_b_in_front,
  output logic                           out_clip_parallel,
  input  wire logic                      psel,
  input  wire logic                      penable,
  input  wire logic                      pwrite,
  input  wire logic [ADDR_W-1:0]         paddr,
  input  wire logic [REG_W-1:0]          pwdata,
  output logic [REG_W-1:0]               prdata,
  output logic                           pready
);

  cfg_t cfg;
  lane_in_t [NUM_LANES-1:0] lane_in;
  flag_t flag_f;
  flag_t fl_r [LANE_LAT];
  logic signed [PIX_W-1:0] pix [NUM_LANES];
  logic acc;

  logic out_valid_r, fa_r, fb_r, par_r;
  logic signed [PIX_W-1:0] pax_r, pay_r, pbx_r, pby_r;

  assign busy = 1'b0;
  assign acc  = start & ~busy;

  eppc_cfg u_cfg (
    .clk, .rst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready, .cfg
  );

  eppc_front u_front (
    .clk, .rst_n, .acc, .cfg,
    .ax(in_end_a_x), .ay(in_end_a_y), .az(in_end_a_z),
    .bx(in_end_b_x), .by(in_end_b_y), .bz(in_end_b_z),
    .lane_o(lane_in), .flag_o(flag_f)
  );

  // Lanes: a.x, a.y, b.x, b.y, crossing x, crossing y.
  for (genvar i = 0; i < NUM_LANES; i++) begin : g_lane
    eppc_lane u_lane (
      .clk, .half(cfg.half), .lin(lane_in[i]), .pix(pix[i])
    );
  end

  // Flags travel alongside the lanes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < LANE_LAT; i++) begin
        fl_r[i] <= '0;
      end
    end else begin
      fl_r[0] <= flag_f;
      for (int i = 1; i < LANE_LAT; i++) begin
        fl_r[i] <= fl_r[i-1];
      end
    end
  end

  // Merge: an endpoint behind the camera takes the plane crossing.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= fl_r[LANE_LAT-1].vld;
    end
    fa_r  <= fl_r[LANE_LAT-1].fa;
    fb_r  <= fl_r[LANE_LAT-1].fb;
    par_r <= fl_r[LANE_LAT-1].par;
    pax_r <= fl_r[LANE_LAT-1].fa ? pix[0] : pix[4];
    pay_r <= fl_r[LANE_LAT-1].fa ? pix[1] : pix[5];
    pbx_r <= fl_r[LANE_LAT-1].fb ? pix[2] : pix[4];
    pby_r <= fl_r[LANE_LAT-1].fb ? pix[3] : pix[5];
  end

  assign out_valid         = out_valid_r;
  assign out_pix_a_x       = pax_r;
  assign out_pix_a_y       = pay_r;
  assign out_pix_b_x       = pbx_r;
  assign out_pix_b_y       = pby_r;
  assign out_a_in_front    = fa_r;
  assign out_b_in_front    = fb_r;
  assign out_clip_parallel = par_r;

  // Every accepted item gives one result after the fixed latency.
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    acc |-> ##(TOTAL_LAT + 1) out_valid)
    else $error("result missing after accepted item");

  // A parallel edge is only flagged when some endpoint needs clipping.
  a_par_needs_clip: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_clip_parallel |-> !(out_a_in_front && out_b_in_front))
    else $error("parallel flag without clipping");

  // A clipped end of a parallel edge sits at the screen center.
  a_par_center: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_clip_parallel && !out_a_in_front |->
      out_pix_a_x == PIX_W'(cfg.half) && out_pix_a_y == PIX_W'(cfg.half))
    else $error("parallel clip not at center");

endmodule
`default_nettype wire

FILE: rtl/eppc_cfg.sv
// Configuration register file with an APB-style port.
// Depends on eppc_pkg.
`default_nettype none
module eppc_cfg
  import eppc_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [REG_W-1:0]  pwdata,
  output logic [REG_W-1:0]       prdata,
  output logic                   pready,
  output cfg_t                   cfg
);

  cfg_t cfg_r;
  logic wr_en;
  logic [IDX_W-1:0] idx;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign idx    = paddr[ADDR_W-1:ADDR_W-IDX_W];
  assign cfg    = cfg_r;

  // Register writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.cam_x    <= -COORD_W'(2560);
      cfg_r.cam_y    <= -COORD_W'(2560);
      cfg_r.cam_z    <= COORD_W'(7680);
      cfg_r.right    <= 48'd3535744321;
      cfg_r.up       <= 48'd231721538740224;
      cfg_r.fwd      <= 48'd231718317465600;
      cfg_r.scr_dist <= DIST_W'(512);
      cfg_r.half     <= HALF_W'(500);
    end else if (wr_en) begin
      unique case (idx)
        REG_CAM_X: cfg_r.cam_x    <= pwdata[COORD_W-1:0];
        REG_CAM_Y: cfg_r.cam_y    <= pwdata[COORD_W-1:0];
        REG_CAM_Z: cfg_r.cam_z    <= pwdata[COORD_W-1:0];
        REG_RIGHT: cfg_r.right    <= pwdata[3*AXIS_W-1:0];
        REG_UP:    cfg_r.up       <= pwdata[3*AXIS_W-1:0];
        REG_FWD:   cfg_r.fwd      <= pwdata[3*AXIS_W-1:0];
        REG_DIST:  cfg_r.scr_dist <= pwdata[DIST_W-1:0];
        REG_HALF:  cfg_r.half     <= pwdata[HALF_W-1:0];
        default: ;
      endcase
    end
  end

  // Read mux.
  always_comb begin
    unique case (idx)
      REG_CAM_X: prdata = REG_W'($unsigned(cfg_r.cam_x));
      REG_CAM_Y: prdata = REG_W'($unsigned(cfg_r.cam_y));
      REG_CAM_Z: prdata = REG_W'($unsigned(cfg_r.cam_z));
      REG_RIGHT: prdata = REG_W'(cfg_r.right);
      REG_UP:    prdata = REG_W'(cfg_r.up);
      REG_FWD:   prdata = REG_W'(cfg_r.fwd);
      REG_DIST:  prdata = REG_W'(cfg_r.scr_dist);
      REG_HALF:  prdata = REG_W'(cfg_r.half);
      default:   prdata = '0;
    endcase
  end

endmodule
`default_nettype wire

FILE: rtl/eppc_front.sv
// Front end: offsets, axis dot products and the projection and clip
// numerators that feed the pixel lanes. Depends on eppc_pkg.
`default_nettype none
module eppc_front
  import eppc_pkg::*;
(
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      acc,
  input  cfg_t                           cfg,
  input  wire logic signed [COORD_W-1:0] ax,
  input  wire logic signed [COORD_W-1:0] ay,
  input  wire logic signed [COORD_W-1:0] az,
  input  wire logic signed [COORD_W-1:0] bx,
  input  wire logic signed [COORD_W-1:0] by,
  input  wire logic signed [COORD_W-1:0] bz,
  output lane_in_t [NUM_LANES-1:0]       lane_o,
  output flag_t                          flag_o
);

  // Valid bits per stage.
  logic v1_r, v2_r, v3_r, v4_r, v5_r;

  // Stage 1 offsets.
  logic signed [DIFF_W-1:0] dax_r, day_r, daz_r, dbx_r, dby_r, dbz_r, ux_r, uy_r, uz_r;
  // Stage 2 dot products.
  logic signed [DOT_W-1:0] ra_r, va_r, za_r, rb_r, vb_r, zb_r, uh_r, uv_r, un_r;
  // Stage 3.
  logic signed [PNUM_W-1:0] pn3_r [4];
  logic signed [NN_W-1:0]   nn3_r;
  logic signed [NUM_W-1:0]  raul_r, rauh_r, vaul_r, vauh_r;
  logic signed [DOT_W-1:0]  uh3_r, uv3_r, un3_r, za3_r, zb3_r;
  spec_t sp3_r [4];
  logic fa3_r, fb3_r, par3_r;
  // Stage 4.
  logic signed [PNUM_W-1:0] pn4_r [4];
  logic signed [NUM_W-1:0]  rau4_r, vau4_r, nuhl_r, nuhh_r, nuvl_r, nuvh_r;
  logic signed [DOT_W-1:0]  un4_r, za4_r, zb4_r;
  spec_t sp4_r [4];
  logic fa4_r, fb4_r, par4_r;
  // Stage 5 lane inputs.
  lane_in_t [NUM_LANES-1:0] lane_r;
  logic fa5_r, fb5_r, par5_r;

  logic signed [DOT_W-1:0] un_abs;

  assign lane_o = lane_r;
  assign flag_o = {v5_r, fa5_r, fb5_r, par5_r};
  assign un_abs = un4_r[DOT_W-1] ? -un4_r : un4_r;

  // Valid pipeline.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else begin
      v1_r <= acc;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
    end
  end

  // Stage 1: offsets from the camera and the edge direction.
  always_ff @(posedge clk) begin
    dax_r <= DIFF_W'(ax) - DIFF_W'(cfg.cam_x);
    day_r <= DIFF_W'(ay) - DIFF_W'(cfg.cam_y);
    daz_r <= DIFF_W'(az) - DIFF_W'(cfg.cam_z);
    dbx_r <= DIFF_W'(bx) - DIFF_W'(cfg.cam_x);
    dby_r <= DIFF_W'(by) - DIFF_W'(cfg.cam_y);
    dbz_r <= DIFF_W'(bz) - DIFF_W'(cfg.cam_z);
    ux_r  <= DIFF_W'(bx) - DIFF_W'(ax);
    uy_r  <= DIFF_W'(by) - DIFF_W'(ay);
    uz_r  <= DIFF_W'(bz) - DIFF_W'(az);
  end

  // Stage 2: dot products with the three axes.
  always_ff @(posedge clk) begin
    ra_r <= dot3(dax_r, day_r, daz_r, cfg.right);
    va_r <= dot3(dax_r, day_r, daz_r, cfg.up);
    za_r <= dot3(dax_r, day_r, daz_r, cfg.fwd);
    rb_r <= dot3(dbx_r, dby_r, dbz_r, cfg.right);
    vb_r <= dot3(dbx_r, dby_r, dbz_r, cfg.up);
    zb_r <= dot3(dbx_r, dby_r, dbz_r, cfg.fwd);
    uh_r <= dot3(ux_r, uy_r, uz_r, cfg.right);
    uv_r <= dot3(ux_r, uy_r, uz_r, cfg.up);
    un_r <= dot3(ux_r, uy_r, uz_r, cfg.fwd);
  end

  // Stage 3: projection numerators, clip partial products and flags.
  always_ff @(posedge clk) begin
    pn3_r[0] <= PNUM_W'(ra_r) * PNUM_W'($signed({1'b0, cfg.scr_dist}));
    pn3_r[1] <= PNUM_W'(va_r) * PNUM_W'($signed({1'b0, cfg.scr_dist}));
    pn3_r[2] <= PNUM_W'(rb_r) * PNUM_W'($signed({1'b0, cfg.scr_dist}));
    pn3_r[3] <= PNUM_W'(vb_r) * PNUM_W'($signed({1'b0, cfg.scr_dist}));
    nn3_r    <= NN_W'($signed({1'b0, cfg.scr_dist, {AXIS_FRAC{1'b0}}})) - NN_W'(za_r);
    raul_r   <= NUM_W'(ra_r) * NUM_W'($signed({1'b0, un_r[SPLIT-1:0]}));
    rauh_r   <= NUM_W'(ra_r) * NUM_W'($signed(un_r[DOT_W-1:SPLIT]));
    vaul_r   <= NUM_W'(va_r) * NUM_W'($signed({1'b0, un_r[SPLIT-1:0]}));
    vauh_r   <= NUM_W'(va_r) * NUM_W'($signed(un_r[DOT_W-1:SPLIT]));
    uh3_r    <= uh_r;
    uv3_r    <= uv_r;
    un3_r    <= un_r;
    za3_r    <= za_r;
    zb3_r    <= zb_r;
    fa3_r    <= ~za_r[DOT_W-1];
    fb3_r    <= ~zb_r[DOT_W-1];
    par3_r   <= (za_r[DOT_W-1] | zb_r[DOT_W-1]) & (un_r == '0);
    // A zero depth saturates by the sign of the screen coordinate, or gives the center when that is zero.
    sp3_r[0] <= (za_r != '0) ? SPEC_NONE : (ra_r == '0) ? SPEC_CTR :
                ra_r[DOT_W-1] ? SPEC_NEG : SPEC_POS;
    sp3_r[1] <= (za_r != '0) ? SPEC_NONE : (va_r == '0) ? SPEC_CTR :
                va_r[DOT_W-1] ? SPEC_NEG : SPEC_POS;
    sp3_r[2] <= (zb_r != '0) ? SPEC_NONE : (rb_r == '0) ? SPEC_CTR :
                rb_r[DOT_W-1] ? SPEC_NEG : SPEC_POS;
    sp3_r[3] <= (zb_r != '0) ? SPEC_NONE : (vb_r == '0) ? SPEC_CTR :
                vb_r[DOT_W-1] ? SPEC_NEG : SPEC_POS;
  end

  // Stage 4: remaining clip partial products, first sums.
  always_ff @(posedge clk) begin
    nuhl_r <= NUM_W'(nn3_r) * NUM_W'($signed({1'b0, uh3_r[SPLIT-1:0]}));
    nuhh_r <= NUM_W'(nn3_r) * NUM_W'($signed(uh3_r[DOT_W-1:SPLIT]));
    nuvl_r <= NUM_W'(nn3_r) * NUM_W'($signed({1'b0, uv3_r[SPLIT-1:0]}));
    nuvh_r <= NUM_W'(nn3_r) * NUM_W'($signed(uv3_r[DOT_W-1:SPLIT]));
    rau4_r <= (rauh_r <<< SPLIT) + raul_r;
    vau4_r <= (vauh_r <<< SPLIT) + vaul_r;
    pn4_r  <= pn3_r;
    sp4_r  <= sp3_r;
    un4_r  <= un3_r;
    za4_r  <= za3_r;
    zb4_r  <= zb3_r;
    fa4_r  <= fa3_r;
    fb4_r  <= fb3_r;
    par4_r <= par3_r;
  end

  // Stage 5: lane inputs.
  always_ff @(posedge clk) begin
    for (int i = 0; i < 4; i++) begin
      lane_r[i].num  <= NUM_W'(pn4_r[i]);
      lane_r[i].flip <= 1'b0;
      lane_r[i].spec <= sp4_r[i];
    end
    lane_r[0].den <= DEN_W'($unsigned(za4_r)) << COORD_FRAC;
    lane_r[1].den <= DEN_W'($unsigned(za4_r)) << COORD_FRAC;
    lane_r[2].den <= DEN_W'($unsigned(zb4_r)) << COORD_FRAC;
    lane_r[3].den <= DEN_W'($unsigned(zb4_r)) << COORD_FRAC;
    lane_r[4].num  <= rau4_r + (nuhh_r <<< SPLIT) + nuhl_r;
    lane_r[5].num  <= vau4_r + (nuvh_r <<< SPLIT) + nuvl_r;
    lane_r[4].flip <= un4_r[DOT_W-1];
    lane_r[5].flip <= un4_r[DOT_W-1];
    lane_r[4].den  <= DEN_W'($unsigned(un_abs)) << (COORD_FRAC + AXIS_FRAC);
    lane_r[5].den  <= DEN_W'($unsigned(un_abs)) << (COORD_FRAC + AXIS_FRAC);
    lane_r[4].spec <= (un4_r == '0) ? SPEC_CTR : SPEC_NONE;
    lane_r[5].spec <= (un4_r == '0) ? SPEC_CTR : SPEC_NONE;
    fa5_r  <= fa4_r;
    fb5_r  <= fb4_r;
    par5_r <= par4_r;
  end

endmodule
`default_nettype wire

FILE: rtl/eppc_lane.sv
// Pixel lane: H + round(H*num/den), capped and saturated, with a
// restoring divider of one quotient bit per stage. Depends on eppc_pkg.
`default_nettype none
module eppc_lane
  import eppc_pkg::*;
(
  input  wire logic              clk,
  input  wire logic [HALF_W-1:0] half,
  input  lane_in_t               lin,
  output logic signed [PIX_W-1:0] pix
);

  // Stage 1: sign and magnitude.
  logic               neg1_r;
  logic [MAG_W-1:0]   mag1_r;
  logic [DEN_W-1:0]   den1_r;
  spec_t              sp1_r;
  // Stage 2: split product with H.
  logic [HM_W-1:0]    plo2_r, phi2_r;
  logic               neg2_r;
  logic [DEN_W-1:0]   den2_r;
  spec_t              sp2_r;
  // Stage 3: rounded dividend.
  logic [N_W-1:0]     n3_r;
  logic               neg3_r;
  logic [DEN_W-1:0]   den3_r;
  spec_t              sp3_r;
  // Divider stages.
  logic [REM_W-1:0]   rem_r [QUO_W+1];
  logic [DVS_W-1:0]   dv_r  [QUO_W+1];
  logic [QUO_W-1:0]   q_r   [QUO_W+1];
  logic               neg_r [QUO_W+1];
  logic               cap_r [QUO_W+1];
  spec_t              sp_r  [QUO_W+1];
  // Output.
  logic signed [PIX_W-1:0] pix_r;

  logic [OFF_W-1:0]        off;
  logic signed [VAL_W-1:0] val;
  logic [DVS_W-1:0]        dvs3;

  assign pix  = pix_r;
  assign dvs3 = {den3_r, 1'b0};

  always_ff @(posedge clk) begin
    neg1_r <= lin.num[NUM_W-1] ^ lin.flip;
    mag1_r <= MAG_W'(lin.num[NUM_W-1] ? -lin.num : lin.num);
    den1_r <= lin.den;
    sp1_r  <= lin.spec;

    plo2_r <= HM_W'(mag1_r[MSPLIT-1:0]) * HM_W'(half);
    phi2_r <= HM_W'(mag1_r[MAG_W-1:MSPLIT]) * HM_W'(half);
    neg2_r <= neg1_r;
    den2_r <= den1_r;
    sp2_r  <= sp1_r;

    // 2*H*|num| + den over 2*den gives round half away from zero.
    n3_r   <= (((N_W'(phi2_r) << MSPLIT) + N_W'(plo2_r)) << 1) + N_W'(den2_r);
    neg3_r <= neg2_r;
    den3_r <= den2_r;
    sp3_r  <= sp2_r;

    // Offset cap check; below the cap the quotient fits QUO_W bits.
    cap_r[0] <= n3_r >= (N_W'(dvs3) << QUO_W);
    rem_r[0] <= n3_r[REM_W-1:0];
    dv_r[0]  <= dvs3;
    q_r[0]   <= '0;
    neg_r[0] <= neg3_r;
    sp_r[0]  <= sp3_r;
  end

  // One quotient bit per stage, most significant first.
  for (genvar j = 0; j < QUO_W; j++) begin : g_div
    logic [REM_W-1:0] sh;
    logic             ge;
    assign sh = REM_W'(dv_r[j]) << (QUO_W - 1 - j);
    assign ge = rem_r[j] >= sh;
    always_ff @(posedge clk) begin
      rem_r[j+1] <= ge ? rem_r[j] - sh : rem_r[j];
      q_r[j+1]   <= {q_r[j][QUO_W-2:0], ge};
      dv_r[j+1]  <= dv_r[j];
      neg_r[j+1] <= neg_r[j];
      cap_r[j+1] <= cap_r[j];
      sp_r[j+1]  <= sp_r[j];
    end
  end

  // Offset from the screen center and saturation.
  always_comb begin
    off = cap_r[QUO_W] ? OFF_CAP : {1'b0, q_r[QUO_W]};
    val = neg_r[QUO_W] ? VAL_W'(half) - VAL_W'(off) : VAL_W'(half) + VAL_W'(off);
  end

  always_ff @(posedge clk) begin
    unique case (sp_r[QUO_W])
      SPEC_POS: pix_r <= PIX_W'(PIX_MAX);
      SPEC_NEG: pix_r <= PIX_W'(PIX_MIN);
      SPEC_CTR: pix_r <= PIX_W'(half);
      default: begin
        if (val > PIX_MAX) begin
          pix_r <= PIX_W'(PIX_MAX);
        end else if (val < PIX_MIN) begin
          pix_r <= PIX_W'(PIX_MIN);
        end else begin
          pix_r <= PIX_W'(val);
        end
      end
    endcase
  end

endmodule
`default_nettype wire
